// ----- hdl/hd_pkg.sv -----
// ----------------------------------------------------------------------------
// hd_pkg : shared types and constants for the haversine distance block
// Fixed-point formats, CORDIC arctangent table and pipeline sizes.
// ----------------------------------------------------------------------------
package hd_pkg;

   localparam int CW           = 34;
   localparam int PW           = 2 * CW;
   localparam int AW           = 27;
   localparam int MAG_W        = 24;
   localparam int A_W          = 31;
   localparam int CORDIC_STEPS = 28;
   localparam int SQ_STEPS     = 31;
   localparam int SQ_W         = 62;
   localparam int SQ_IN_W      = 61;
   localparam int SQ_ROOT_W    = 31;
   localparam int DP_W         = 44;
   localparam int DIST_W       = 23;

   localparam logic signed [AW-1:0] DEG90  = AW'(11796480);
   localparam logic signed [AW-1:0] DEG180 = AW'(23592960);
   localparam logic signed [AW-1:0] DEG360 = AW'(47185920);

   localparam logic [26:0]          RAD_PER_DEG = 27'd74961321;
   localparam logic signed [CW-1:0] INV_GAIN    = CW'(652032874);
   localparam logic signed [CW-1:0] ONE_Q30     = CW'(1 << 30);
   localparam logic [12:0]          EARTH_R     = 13'd6371;
   localparam logic [DIST_W-1:0]    DIST_MAX    = DIST_W'(5123840);

   localparam logic signed [CW-1:0] ATAN_TAB [CORDIC_STEPS] = '{
      CW'(843314856), CW'(497837829), CW'(263043836), CW'(133525158),
      CW'(67021686),  CW'(33543515),  CW'(16775850),  CW'(8388437),
      CW'(4194282),   CW'(2097149),   CW'(1048575),   CW'(524287),
      CW'(262143),    CW'(131071),    CW'(65535),     CW'(32767),
      CW'(16383),     CW'(8191),      CW'(4095),      CW'(2047),
      CW'(1023),      CW'(511),       CW'(255),       CW'(127),
      CW'(63),        CW'(31),        CW'(15),        CW'(7)
   };

   typedef enum logic {
      CORDIC_ROTATE,
      CORDIC_VECTOR
   } cordic_mode_type;

endpackage

// ----- hdl/haversine_distance.sv -----
// ----------------------------------------------------------------------------
// haversine_distance : great-circle distance between two points
// Haversine formula on a 6371 km sphere, degrees Q16 in, km Q8 out.
// ----------------------------------------------------------------------------
// Usage:
//   req channel: one beat carries both points (latitudes and longitudes in
//   degrees, signed, 16 fraction bits). rsp channel: one beat per request with
//   the distance in km, unsigned, 8 fraction bits, saturated at 20015 km.
//   Throughput is one beat per cycle when the receiver does not stall. A beat
//   passes through the 28-stage sine/cosine CORDIC, the 31-stage square root
//   and the 28-stage arctangent CORDIC, plus nine arithmetic stages.
//   The pipeline moves as one: when a result waits and rsp_tready is low,
//   every stage holds and req_tready drops; nothing is lost or repeated.
//   Reset clears all valid bits; the block keeps no other state and needs
//   no configuration.
// ----------------------------------------------------------------------------
module haversine_distance
   import hd_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          req_tvalid,
   output logic          req_tready,
   // org_lat[23:0], org_lon[48:24], dst_lat[72:49], dst_lon[97:73]
   input  logic [103:0]  req_tdata,
   output logic          rsp_tvalid,
   input  logic          rsp_tready,
   // distance_km[22:0]
   output logic [23:0]   rsp_tdata
);

   localparam int N_STAGES = 3 + CORDIC_STEPS + 4 + SQ_STEPS + CORDIC_STEPS + 2;
   localparam int A_STAGE  = 3 + CORDIC_STEPS + 3;

   logic                adv;
   logic [N_STAGES-1:0] vld_ff;

   logic signed [23:0]  b_lat;
   logic signed [24:0]  b_lon;
   logic signed [23:0]  t_lat;
   logic signed [24:0]  t_lon;

   logic signed [AW-1:0] ang_in [4];
   logic signed [AW-1:0] ang_ff [4];
   logic signed [AW-1:0] r_w    [4];
   logic [MAG_W-1:0]     mag_in [4];
   logic [MAG_W-1:0]     mag_ff [4];
   logic                 neg_in [4];
   logic                 neg_ff [4];
   logic                 flip_in [4];
   logic                 flip_ff [4];
   logic [50:0]          rp     [4];
   logic signed [CW-1:0] zabs   [4];
   logic signed [CW-1:0] z0_in  [4];
   logic signed [CW-1:0] z0_ff  [4];
   logic                 flip2_ff [4];

   logic signed [CW-1:0] rx [4];
   logic signed [CW-1:0] ry [4];
   logic signed [CW-1:0] rz [4];
   logic                 rt [4];

   logic signed [PW-1:0] pc_ff, ps1_ff, ps2_ff, pp_ff;
   logic                 cneg_ff;
   logic signed [CW-1:0] t_ff, sq1_ff, sq2_ff, sq1b_ff, asum;
   logic [A_W-1:0]       a_in, a_ff, b_ff;
   logic [SQ_ROOT_W-1:0] sa, sb;

   logic signed [CW-1:0] vx, vy, vz;
   logic                 vt;
   logic [30:0]          zc;
   logic [DP_W-1:0]      dp_ff, dsum;
   logic [DIST_W-1:0]    d_w, rsp_data_ff;

   assign adv        = !vld_ff[N_STAGES-1] || rsp_tready;
   assign req_tready = adv;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (adv) begin
         vld_ff <= {vld_ff[N_STAGES-2:0], req_tvalid};
      end
   end

   assign b_lat = req_tdata[23:0];
   assign b_lon = req_tdata[48:24];
   assign t_lat = req_tdata[72:49];
   assign t_lon = req_tdata[97:73];

   always_comb begin
      ang_in[0] = AW'(t_lat) - AW'(b_lat);
      ang_in[1] = AW'(t_lon) - AW'(b_lon);
      ang_in[2] = AW'(b_lat) + AW'(b_lat);
      ang_in[3] = AW'(t_lat) + AW'(t_lat);
   end

   always_comb begin
      for (int k = 0; k < 4; k++) begin
         r_w[k] = ang_ff[k];
         if (r_w[k] >= DEG180) begin
            r_w[k] = r_w[k] - DEG360;
         end
         if (r_w[k] < -DEG180) begin
            r_w[k] = r_w[k] + DEG360;
         end
         flip_in[k] = 1'b0;
         if (r_w[k] > DEG90) begin
            r_w[k]     = DEG180 - r_w[k];
            flip_in[k] = 1'b1;
         end else if (r_w[k] < -DEG90) begin
            r_w[k]     = -DEG180 - r_w[k];
            flip_in[k] = 1'b1;
         end
         neg_in[k] = r_w[k][AW-1];
         mag_in[k] = neg_in[k] ? MAG_W'(-r_w[k]) : MAG_W'(r_w[k]);
      end
   end

   always_comb begin
      for (int k = 0; k < 4; k++) begin
         rp[k]    = 51'(mag_ff[k]) * 51'(RAD_PER_DEG) + 51'(1 << 18);
         zabs[k]  = CW'(rp[k][50:19]);
         z0_in[k] = neg_ff[k] ? -zabs[k] : zabs[k];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int k = 0; k < 4; k++) begin
            ang_ff[k]   <= ang_in[k];
            mag_ff[k]   <= mag_in[k];
            neg_ff[k]   <= neg_in[k];
            flip_ff[k]  <= flip_in[k];
            z0_ff[k]    <= z0_in[k];
            flip2_ff[k] <= flip_ff[k];
         end
      end
   end

   for (genvar k = 0; k < 4; k++) begin : g_trig
      hd_cordic #(.TAG_W(1)) u_rot (
         .clock   (clock),
         .en      (adv),
         .mode    (CORDIC_ROTATE),
         .x_in    (INV_GAIN),
         .y_in    ('0),
         .z_in    (z0_ff[k]),
         .tag_in  (flip2_ff[k]),
         .x_out   (rx[k]),
         .y_out   (ry[k]),
         .z_out   (rz[k]),
         .tag_out (rt[k])
      );
   end

   always_comb begin
      asum = sq1b_ff + CW'(pp_ff >>> 30);
      if (asum < 0) begin
         a_in = '0;
      end else if (asum > ONE_Q30) begin
         a_in = A_W'(ONE_Q30);
      end else begin
         a_in = asum[A_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         pc_ff   <= PW'(rx[2]) * PW'(rx[3]);
         cneg_ff <= rt[2] ^ rt[3];
         ps1_ff  <= PW'(ry[0]) * PW'(ry[0]);
         ps2_ff  <= PW'(ry[1]) * PW'(ry[1]);
         t_ff    <= CW'((cneg_ff ? -pc_ff : pc_ff) >>> 30);
         sq1_ff  <= CW'(ps1_ff >>> 30);
         sq2_ff  <= CW'(ps2_ff >>> 30);
         pp_ff   <= PW'(t_ff) * PW'(sq2_ff);
         sq1b_ff <= sq1_ff;
         a_ff    <= a_in;
         b_ff    <= A_W'(ONE_Q30) - a_in;
      end
   end

   hd_isqrt u_sqrt_a (
      .clock    (clock),
      .en       (adv),
      .v_in     ({a_ff, 30'b0}),
      .root_out (sa)
   );

   hd_isqrt u_sqrt_b (
      .clock    (clock),
      .en       (adv),
      .v_in     ({b_ff, 30'b0}),
      .root_out (sb)
   );

   hd_cordic #(.TAG_W(1)) u_atan (
      .clock   (clock),
      .en      (adv),
      .mode    (CORDIC_VECTOR),
      .x_in    (CW'(sb)),
      .y_in    (CW'(sa)),
      .z_in    ('0),
      .tag_in  (1'b0),
      .x_out   (vx),
      .y_out   (vy),
      .z_out   (vz),
      .tag_out (vt)
   );

   always_comb begin
      zc   = vz[CW-1] ? '0 : vz[30:0];
      dsum = dp_ff + DP_W'(1 << 20);
      d_w  = (dsum[DP_W-1:21] > DIST_MAX) ? DIST_MAX : DIST_W'(dsum[DP_W-1:21]);
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         dp_ff       <= DP_W'(zc) * DP_W'(EARTH_R);
         rsp_data_ff <= d_w;
      end
   end

   assign rsp_tvalid = vld_ff[N_STAGES-1];
   assign rsp_tdata  = {1'b0, rsp_data_ff};

   a_dist_max : assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_data_ff <= DIST_MAX)
      else $error("distance above saturation limit");

   a_accept_enters : assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> vld_ff[0])
      else $error("accepted beat missing from first stage");

   a_stall_holds : assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=> $stable(vld_ff) && $stable(rsp_data_ff))
      else $error("pipeline moved during stall");

   a_term_range : assert property (@(posedge clock) disable iff (reset)
      vld_ff[A_STAGE] |-> (a_ff <= A_W'(ONE_Q30)) && (a_ff + b_ff == A_W'(ONE_Q30)))
      else $error("haversine term out of range");

endmodule

// ----- hdl/hd_cordic.sv -----
// ----------------------------------------------------------------------------
// hd_cordic : pipelined CORDIC, one micro-rotation per register stage
// Rotation mode drives z to zero, vectoring mode drives y to zero.
// ----------------------------------------------------------------------------
module hd_cordic
   import hd_pkg::*;
#(
   parameter int TAG_W = 1
) (
   input  logic                   clock,
   input  logic                   en,
   input  cordic_mode_type        mode,
   input  logic signed [CW-1:0]   x_in,
   input  logic signed [CW-1:0]   y_in,
   input  logic signed [CW-1:0]   z_in,
   input  logic [TAG_W-1:0]       tag_in,
   output logic signed [CW-1:0]   x_out,
   output logic signed [CW-1:0]   y_out,
   output logic signed [CW-1:0]   z_out,
   output logic [TAG_W-1:0]       tag_out
);

   logic signed [CW-1:0] x_ff [CORDIC_STEPS];
   logic signed [CW-1:0] y_ff [CORDIC_STEPS];
   logic signed [CW-1:0] z_ff [CORDIC_STEPS];
   logic [TAG_W-1:0]     tag_ff [CORDIC_STEPS];

   logic signed [CW-1:0] xs [CORDIC_STEPS];
   logic signed [CW-1:0] ys [CORDIC_STEPS];
   logic signed [CW-1:0] zs [CORDIC_STEPS];
   logic [TAG_W-1:0]     ts [CORDIC_STEPS];
   logic signed [CW-1:0] x_in_s [CORDIC_STEPS];
   logic signed [CW-1:0] y_in_s [CORDIC_STEPS];
   logic signed [CW-1:0] z_in_s [CORDIC_STEPS];
   logic                 ccw [CORDIC_STEPS];

   always_comb begin
      xs[0] = x_in;
      ys[0] = y_in;
      zs[0] = z_in;
      ts[0] = tag_in;
      for (int i = 1; i < CORDIC_STEPS; i++) begin
         xs[i] = x_ff[i-1];
         ys[i] = y_ff[i-1];
         zs[i] = z_ff[i-1];
         ts[i] = tag_ff[i-1];
      end
   end

   always_comb begin
      for (int i = 0; i < CORDIC_STEPS; i++) begin
         if (mode == CORDIC_ROTATE) begin
            ccw[i] = !zs[i][CW-1];
         end else begin
            ccw[i] = !(ys[i] > 0);
         end
         if (ccw[i]) begin
            x_in_s[i] = xs[i] - (ys[i] >>> i);
            y_in_s[i] = ys[i] + (xs[i] >>> i);
            z_in_s[i] = zs[i] - ATAN_TAB[i];
         end else begin
            x_in_s[i] = xs[i] + (ys[i] >>> i);
            y_in_s[i] = ys[i] - (xs[i] >>> i);
            z_in_s[i] = zs[i] + ATAN_TAB[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int i = 0; i < CORDIC_STEPS; i++) begin
            x_ff[i]   <= x_in_s[i];
            y_ff[i]   <= y_in_s[i];
            z_ff[i]   <= z_in_s[i];
            tag_ff[i] <= ts[i];
         end
      end
   end

   assign x_out   = x_ff[CORDIC_STEPS-1];
   assign y_out   = y_ff[CORDIC_STEPS-1];
   assign z_out   = z_ff[CORDIC_STEPS-1];
   assign tag_out = tag_ff[CORDIC_STEPS-1];

endmodule

// ----- hdl/hd_isqrt.sv -----
// ----------------------------------------------------------------------------
// hd_isqrt : pipelined floor integer square root
// One result bit per register stage, restoring method.
// ----------------------------------------------------------------------------
module hd_isqrt
   import hd_pkg::*;
(
   input  logic                  clock,
   input  logic                  en,
   input  logic [SQ_IN_W-1:0]    v_in,
   output logic [SQ_ROOT_W-1:0]  root_out
);

   logic [SQ_W-1:0] rem_ff  [SQ_STEPS];
   logic [SQ_W-1:0] root_ff [SQ_STEPS];
   logic [SQ_W-1:0] rem_s   [SQ_STEPS];
   logic [SQ_W-1:0] root_s  [SQ_STEPS];
   logic [SQ_W-1:0] rem_in  [SQ_STEPS];
   logic [SQ_W-1:0] root_in [SQ_STEPS];
   logic [SQ_W-1:0] bit_w   [SQ_STEPS];
   logic [SQ_W-1:0] trial   [SQ_STEPS];

   always_comb begin
      rem_s[0]  = SQ_W'(v_in);
      root_s[0] = '0;
      for (int j = 1; j < SQ_STEPS; j++) begin
         rem_s[j]  = rem_ff[j-1];
         root_s[j] = root_ff[j-1];
      end
   end

   always_comb begin
      for (int j = 0; j < SQ_STEPS; j++) begin
         bit_w[j] = SQ_W'(1) << (2 * (SQ_STEPS - 1 - j));
         trial[j] = root_s[j] + bit_w[j];
         if (rem_s[j] >= trial[j]) begin
            rem_in[j]  = rem_s[j] - trial[j];
            root_in[j] = (root_s[j] >> 1) + bit_w[j];
         end else begin
            rem_in[j]  = rem_s[j];
            root_in[j] = root_s[j] >> 1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int j = 0; j < SQ_STEPS; j++) begin
            rem_ff[j]  <= rem_in[j];
            root_ff[j] <= root_in[j];
         end
      end
   end

   assign root_out = root_ff[SQ_STEPS-1][SQ_ROOT_W-1:0];

endmodule

// ----- verif/tb_haversine_distance.sv -----
// ----------------------------------------------------------------------------
// tb_haversine_distance : self-checking bench for the haversine distance block
// A bit-exact fixed-point distance predictor fills a queue of expected
// distances for each accepted request beat; each response beat is compared
// in order. Directed corner points, then random point pairs under several
// idle and stall phases.
// ----------------------------------------------------------------------------
module tb_haversine_distance
   import hd_pkg::*;
;
   timeunit 1ns;
   timeprecision 1ps;

   localparam longint ONE   = 64'sd1 << 30;
   localparam longint D90   = 64'sd90 << 17;
   localparam longint D180  = 64'sd180 << 17;
   localparam longint D360  = 64'sd360 << 17;
   localparam longint LAT_MAX = 5898240;
   localparam longint LON_MAX = 11796480;
   localparam int     LATENCY = 96;

   typedef struct packed {
      logic signed [24:0] dst_lon;
      logic signed [23:0] dst_lat;
      logic signed [24:0] org_lon;
      logic signed [23:0] org_lat;
   } coords_type;

   class distance_board;
      logic [DIST_W-1:0] pending[$];
      int errors;

      static function longint fshr(longint v, int s);
         return v >>> s;
      endfunction

      static function longint isqrt(longint unsigned v);
         longint unsigned r, b;
         r = 0;
         b = 64'd1 << 62;
         while (b > v) b >>= 2;
         while (b != 0) begin
            if (v >= r + b) begin
               v -= r + b;
               r = (r >> 1) + b;
            end else begin
               r >>= 1;
            end
            b >>= 2;
         end
         return longint'(r);
      endfunction

      static function void sin_cos(longint deg, output longint s, output longint c);
         longint r, x, y, z, nx;
         longint unsigned mag, rad;
         bit flip;
         r = deg % D360;
         flip = 0;
         if (r >= D180) r -= D360;
         if (r < -D180) r += D360;
         if (r > D90) begin
            r = D180 - r;
            flip = 1;
         end else if (r < -D90) begin
            r = -D180 - r;
            flip = 1;
         end
         mag = r < 0 ? -r : r;
         rad = (mag * 74961321 + (64'd1 << 18)) >> 19;
         z = r < 0 ? -longint'(rad) : longint'(rad);
         x = 652032874;
         y = 0;
         for (int i = 0; i < CORDIC_STEPS; i++) begin
            if (z >= 0) begin
               nx = x - fshr(y, i);
               y = y + fshr(x, i);
               z -= longint'(ATAN_TAB[i]);
            end else begin
               nx = x + fshr(y, i);
               y = y - fshr(x, i);
               z += longint'(ATAN_TAB[i]);
            end
            x = nx;
         end
         s = y;
         c = flip ? -x : x;
      endfunction

      static function logic [DIST_W-1:0] great_circle(coords_type p);
         longint la1, lo1, la2, lo2, s1, s2, c1, c2, dm, a, t, x, y, z, nx;
         longint unsigned d;
         la1 = longint'(p.org_lat);
         lo1 = longint'(p.org_lon);
         la2 = longint'(p.dst_lat);
         lo2 = longint'(p.dst_lon);
         sin_cos(la2 - la1, s1, dm);
         sin_cos(lo2 - lo1, s2, dm);
         sin_cos(la1 * 2, dm, c1);
         sin_cos(la2 * 2, dm, c2);
         t = fshr(c1 * c2, 30);
         a = fshr(s1 * s1, 30) + fshr(t * fshr(s2 * s2, 30), 30);
         if (a < 0) a = 0;
         if (a > ONE) a = ONE;
         y = isqrt(a << 30);
         x = isqrt((ONE - a) << 30);
         z = 0;
         for (int i = 0; i < CORDIC_STEPS; i++) begin
            if (y > 0) begin
               nx = x + fshr(y, i);
               y = y - fshr(x, i);
               z += longint'(ATAN_TAB[i]);
            end else begin
               nx = x - fshr(y, i);
               y = y + fshr(x, i);
               z -= longint'(ATAN_TAB[i]);
            end
            x = nx;
         end
         if (z < 0) z = 0;
         d = (longint'(z) * 6371 + (64'd1 << 20)) >> 21;
         if (d > 5123840) d = 5123840;
         return d[DIST_W-1:0];
      endfunction

      function void note_request(coords_type p);
         pending.insert(pending.size(), great_circle(p));
      endfunction

      function void check_response(logic [23:0] data);
         logic [DIST_W-1:0] exp_d;
         if (pending.size() == 0) begin
            $error("unexpected response beat: distance_km=%0d", data[DIST_W-1:0]);
            errors++;
            return;
         end
         exp_d = pending.pop_front();
         if (data[DIST_W-1:0] !== exp_d) begin
            $error("distance_km mismatch: expected %0d, actual %0d", exp_d,
                   data[DIST_W-1:0]);
            errors++;
         end
      endfunction
   endclass

   logic clock = 0, reset = 1;
   logic req_tvalid = 0, req_tready;
   logic [103:0] req_tdata = '0;
   logic rsp_tvalid, rsp_tready = 0;
   logic [23:0] rsp_tdata;
   int send_idle = 0, recv_stall = 0;
   distance_board board = new();

   haversine_distance uut (.*);

   always begin
      #4 clock = 1;
      #4 clock = 0;
   end

   always @(posedge clock) begin
      if (!reset && req_tvalid && req_tready)
         board.note_request(coords_type'(req_tdata[97:0]));
      if (!reset && rsp_tvalid && rsp_tready) board.check_response(rsp_tdata);
      rsp_tready <= !reset && ($urandom_range(99) >= recv_stall);
   end

   task automatic send(coords_type p);
      while ($urandom_range(99) < send_idle) begin
         req_tvalid <= 0;
         @(posedge clock);
      end
      req_tvalid <= 1;
      req_tdata <= {6'b0, p};
      do @(posedge clock); while (!req_tready);
   endtask

   task automatic drain();
      req_tvalid <= 0;
      @(posedge clock);
      while (board.pending.size() != 0) @(posedge clock);
   endtask

   function automatic longint pick(longint lim);
      case ($urandom_range(9))
         0: return lim;
         1: return -lim;
         2: return 0;
         default: return longint'($urandom_range(32'(2 * lim))) - lim;
      endcase
   endfunction

   function automatic coords_type random_pair();
      coords_type p;
      int k;
      k = $urandom_range(19);
      p.org_lat = 24'(pick(LAT_MAX));
      p.org_lon = 25'(pick(LON_MAX));
      if (k == 0) begin
         p = coords_type'(98'({$urandom, $urandom, $urandom, $urandom}));
      end else if (k == 1) begin
         p.dst_lat = -p.org_lat;
         p.dst_lon = 25'(longint'(p.org_lon) + (p.org_lon < 0 ? LON_MAX : -LON_MAX));
      end else if (k == 2) begin
         p.dst_lat = 24'(longint'(p.org_lat) + longint'($urandom_range(64)) - 32);
         p.dst_lon = 25'(longint'(p.org_lon) + longint'($urandom_range(64)) - 32);
      end else begin
         p.dst_lat = 24'(pick(LAT_MAX));
         p.dst_lon = 25'(pick(LON_MAX));
      end
      return p;
   endfunction

   function automatic coords_type pt(longint a, longint b, longint c, longint d);
      coords_type p;
      p.org_lat = 24'(a);
      p.org_lon = 25'(b);
      p.dst_lat = 24'(c);
      p.dst_lon = 25'(d);
      return p;
   endfunction

   initial begin
      repeat (3) @(posedge clock);
      reset <= 0;
      @(posedge clock);
      send(pt(0, 0, 0, 0));
      send(pt(LAT_MAX, 0, -LAT_MAX, 0));
      send(pt(0, 0, 0, LON_MAX));
      send(pt(0, -LON_MAX, 0, LON_MAX));
      send(pt(LAT_MAX, LON_MAX, LAT_MAX, -LON_MAX));
      send(pt(-LAT_MAX, -LON_MAX, LAT_MAX, LON_MAX));
      send(pt(0, 0, 0, 11796479));
      send(pt(1, 1, -1, -1));
      send(pt(LAT_MAX / 2, 0, LAT_MAX / 2, 1));
      send(pt(-8388608, -16777216, 8388607, 16777215));
      send(pt(8388607, 16777215, -8388608, -16777216));
      send(pt(-1, -1, -1, -1));
      send(pt(3276800, 6553600, -2621440, -5242880));
      send(pt(0, 5898240, 0, -5898240));
      send(pt(-LAT_MAX, 0, -LAT_MAX, LON_MAX));
      drain();
      for (int ph = 0; ph < 4; ph++) begin
         send_idle  = ph == 1 || ph == 3 ? (ph == 1 ? 68 : 35) : 0;
         recv_stall = ph == 2 ? 68 : (ph == 3 ? 35 : 0);
         for (int i = 0; i < 410; i++) send(random_pair());
         if (ph == 1) drain();
      end
      drain();
      repeat (LATENCY + 20) @(posedge clock);
      if (board.errors == 0 && board.pending.size() == 0)
         $display("tb_haversine_distance: PASS");
      else
         $display("tb_haversine_distance: FAIL");
      $finish;
   end

   initial begin
      #2ms;
      $display("tb_haversine_distance: FAIL");
      $finish;
   end
endmodule
